FILE: sv/two_patch_logistic_harvest_sim_defines.svh
// Assertion macros shared by the checker files of the harvest simulator.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef TWO_PATCH_LOGISTIC_HARVEST_SIM_DEFINES_SVH
`define TWO_PATCH_LOGISTIC_HARVEST_SIM_DEFINES_SVH

// consequent must hold in the same cycle
`define HSIM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define HSIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hsim_pkg.sv
// Package for the two-patch harvest simulator: payload types, ALU micro-ops,
// register ids and the micro-op program table. No dependencies.
package hsim_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW        = 48;
  localparam int PCW       = 6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [16:0] growth_rate;
    logic [23:0] capacity;
    logic [15:0] mixing_rate;
    logic [15:0] harvest_fraction;
    logic [15:0] protected_share;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] final_yield;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} alu_op_t;

  typedef enum logic [4:0] {
    RG_ZERO, RG_ONE, RG_B, RG_O, RG_Q, RG_MU, RG_R, RG_U, RG_P, RG_M,
    RG_ONEP, RG_ONEU, RG_KIN, RG_KOUT, RG_KALL, RG_T1, RG_T2, RG_T3,
    RG_FLOW, RG_NB, RG_Y
  } reg_id_t;

  typedef struct packed {
    alu_op_t op;
    reg_id_t dst;
    reg_id_t a;
    reg_id_t b;
    logic    last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic               onep_zero;
    logic               kin_zero;
    logic               kout_zero;
    logic               kall_zero;
    logic signed [47:0] yield;
  } dp_sts_t;

  // program entry points
  localparam logic [PCW-1:0] PC_INIT  = 6'd0;
  localparam logic [PCW-1:0] PC_QDIV  = 6'd7;
  localparam logic [PCW-1:0] PC_YEAR1 = 6'd8;
  localparam logic [PCW-1:0] PC_YEAR0 = 6'd26;

  function automatic uop_t mk(alu_op_t op, reg_id_t d, reg_id_t a, reg_id_t b,
                              logic l);
    uop_t u;
    u.op   = op;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    u.last = l;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      // setup
      6'd0:  u = mk(OP_SUB, RG_ONEP, RG_ONE,  RG_P,    1'b0);
      6'd1:  u = mk(OP_SUB, RG_ONEU, RG_ONE,  RG_U,    1'b0);
      6'd2:  u = mk(OP_MUL, RG_KIN,  RG_KALL, RG_P,    1'b0);
      6'd3:  u = mk(OP_MUL, RG_KOUT, RG_KALL, RG_ONEP, 1'b0);
      6'd4:  u = mk(OP_MUL, RG_MU,   RG_M,    RG_ONEP, 1'b0);
      6'd5:  u = mk(OP_ADD, RG_B,    RG_KIN,  RG_ZERO, 1'b0);
      6'd6:  u = mk(OP_ADD, RG_O,    RG_KOUT, RG_ZERO, 1'b1);
      6'd7:  u = mk(OP_DIV, RG_Q,    RG_P,    RG_ONEP, 1'b1);
      // year, growth per patch
      6'd8:  u = mk(OP_MUL, RG_T1,   RG_Q,    RG_O,    1'b0);
      6'd9:  u = mk(OP_SUB, RG_T1,   RG_B,    RG_T1,   1'b0);
      6'd10: u = mk(OP_MUL, RG_FLOW, RG_MU,   RG_T1,   1'b0);
      6'd11: u = mk(OP_MUL, RG_T1,   RG_R,    RG_B,    1'b0);
      6'd12: u = mk(OP_DIV, RG_T2,   RG_B,    RG_KIN,  1'b0);
      6'd13: u = mk(OP_SUB, RG_T2,   RG_ONE,  RG_T2,   1'b0);
      6'd14: u = mk(OP_MUL, RG_T1,   RG_T1,   RG_T2,   1'b0);
      6'd15: u = mk(OP_ADD, RG_NB,   RG_B,    RG_T1,   1'b0);
      6'd16: u = mk(OP_SUB, RG_NB,   RG_NB,   RG_FLOW, 1'b0);
      6'd17: u = mk(OP_MUL, RG_T1,   RG_R,    RG_O,    1'b0);
      6'd18: u = mk(OP_DIV, RG_T2,   RG_O,    RG_KOUT, 1'b0);
      6'd19: u = mk(OP_SUB, RG_T2,   RG_ONE,  RG_T2,   1'b0);
      6'd20: u = mk(OP_MUL, RG_T1,   RG_T1,   RG_T2,   1'b0);
      6'd21: u = mk(OP_MUL, RG_T2,   RG_ONEU, RG_O,    1'b0);
      6'd22: u = mk(OP_ADD, RG_T2,   RG_T2,   RG_T1,   1'b0);
      6'd23: u = mk(OP_ADD, RG_O,    RG_T2,   RG_FLOW, 1'b0);
      6'd24: u = mk(OP_ADD, RG_B,    RG_NB,   RG_ZERO, 1'b0);
      6'd25: u = mk(OP_MUL, RG_Y,    RG_U,    RG_O,    1'b1);
      // year, growth on pooled biomass
      6'd26: u = mk(OP_MUL, RG_T1,   RG_Q,    RG_O,    1'b0);
      6'd27: u = mk(OP_SUB, RG_T1,   RG_B,    RG_T1,   1'b0);
      6'd28: u = mk(OP_MUL, RG_FLOW, RG_MU,   RG_T1,   1'b0);
      6'd29: u = mk(OP_ADD, RG_T3,   RG_B,    RG_O,    1'b0);
      6'd30: u = mk(OP_MUL, RG_T1,   RG_R,    RG_T3,   1'b0);
      6'd31: u = mk(OP_DIV, RG_T2,   RG_T3,   RG_KALL, 1'b0);
      6'd32: u = mk(OP_SUB, RG_T2,   RG_ONE,  RG_T2,   1'b0);
      6'd33: u = mk(OP_MUL, RG_T1,   RG_T1,   RG_T2,   1'b0);
      6'd34: u = mk(OP_MUL, RG_T2,   RG_P,    RG_T1,   1'b0);
      6'd35: u = mk(OP_ADD, RG_NB,   RG_B,    RG_T2,   1'b0);
      6'd36: u = mk(OP_SUB, RG_NB,   RG_NB,   RG_FLOW, 1'b0);
      6'd37: u = mk(OP_MUL, RG_T2,   RG_ONEP, RG_T1,   1'b0);
      6'd38: u = mk(OP_MUL, RG_T3,   RG_ONEU, RG_O,    1'b0);
      6'd39: u = mk(OP_ADD, RG_T3,   RG_T3,   RG_T2,   1'b0);
      6'd40: u = mk(OP_ADD, RG_O,    RG_T3,   RG_FLOW, 1'b0);
      6'd41: u = mk(OP_ADD, RG_B,    RG_NB,   RG_ZERO, 1'b0);
      6'd42: u = mk(OP_MUL, RG_Y,    RG_U,    RG_O,    1'b1);
      default: u = mk(OP_ADD, RG_T1, RG_ZERO, RG_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

FILE: sv/hsim_dp.sv
// Datapath of the harvest simulator: operand registers and one shared
// saturating ALU (add/sub, 4-step multiply, bit-serial divide). Uses hsim_pkg.
module hsim_dp (
  input  logic              clk,
  input  logic              rst,
  input  hsim_pkg::in_item_t request,
  input  hsim_pkg::dp_cmd_t  cmd,
  output hsim_pkg::dp_sts_t  sts
);
  import hsim_pkg::*;

  localparam int DVD_W = VW + FRAC_BITS;
  localparam int CW    = $clog2(DVD_W + 1);
  localparam int PW    = 2 * VW;
  localparam int HW    = VW / 2;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic [VW-1:0] VMAX  = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN  = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic [VW-1:0] b, o, q, mu, r, u, p, m, onep, oneu, kin, kout, kall;
    logic [VW-1:0] t1, t2, t3, flow, nb, y;
  } rf_t;

  rf_t rf;

  function automatic logic [VW-1:0] sel(rf_t f, reg_id_t id);
    logic [VW-1:0] v;
    case (id)
      RG_ZERO: v = '0;
      RG_ONE:  v = ONE_V;
      RG_B:    v = f.b;
      RG_O:    v = f.o;
      RG_Q:    v = f.q;
      RG_MU:   v = f.mu;
      RG_R:    v = f.r;
      RG_U:    v = f.u;
      RG_P:    v = f.p;
      RG_M:    v = f.m;
      RG_ONEP: v = f.onep;
      RG_ONEU: v = f.oneu;
      RG_KIN:  v = f.kin;
      RG_KOUT: v = f.kout;
      RG_KALL: v = f.kall;
      RG_T1:   v = f.t1;
      RG_T2:   v = f.t2;
      RG_T3:   v = f.t3;
      RG_FLOW: v = f.flow;
      RG_NB:   v = f.nb;
      RG_Y:    v = f.y;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VW-1:0] mag(logic [VW-1:0] v);
    return v[VW-1] ? (~v + VW'(1)) : v;
  endfunction

  logic [VW-1:0]    va, vb;
  logic             run, done, sat;
  alu_op_t          op;
  reg_id_t          dst;
  logic [VW-1:0]    opa, opb, ma, mb;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic [PW-1:0]    acc;
  logic [DVD_W-1:0] dvd, quo;
  logic [VW:0]      rem;

  logic [VW:0]      sum;
  logic [VW-1:0]    as_res;
  logic             as_sat;
  logic [HW-1:0]    ah, bh;
  logic [VW-1:0]    pp;
  logic [PW-1:0]    pp_sh;
  logic [VW:0]      remsh;
  logic             ge;
  logic [PW-1:0]    fin_mag, lim;
  logic             m_over;
  logic [VW-1:0]    m_mag, m_res;
  logic [VW-1:0]    res;
  logic             res_sat;

  always_comb begin
    va = sel(rf, cmd.uop.a);
    vb = sel(rf, cmd.uop.b);
  end

  // saturating add / subtract
  always_comb begin
    if (op == OP_SUB) begin
      sum = {opa[VW-1], opa} - {opb[VW-1], opb};
    end else begin
      sum = {opa[VW-1], opa} + {opb[VW-1], opb};
    end
    as_sat = sum[VW] != sum[VW-1];
    as_res = as_sat ? (sum[VW] ? VMIN : VMAX) : sum[VW-1:0];
  end

  // multiply partial products, one 24x24 per step
  always_comb begin
    ah    = cnt[1] ? ma[VW-1:HW] : ma[HW-1:0];
    bh    = cnt[0] ? mb[VW-1:HW] : mb[HW-1:0];
    pp    = VW'(ah) * VW'(bh);
    pp_sh = PW'(pp) << (HW * (32'(cnt[1]) + 32'(cnt[0])));
  end

  // restoring divide step
  always_comb begin
    remsh = {rem[VW-1:0], dvd[DVD_W-1]};
    ge    = remsh >= {1'b0, mb};
  end

  // magnitude saturation shared by multiply and divide
  always_comb begin
    fin_mag = (op == OP_MUL) ? (acc >> FRAC_BITS) : PW'(quo);
    lim     = neg ? PW'(VMIN) : PW'(VMAX);
    m_over  = fin_mag > lim;
    m_mag   = m_over ? lim[VW-1:0] : fin_mag[VW-1:0];
    m_res   = neg ? (~m_mag + VW'(1)) : m_mag;
    if (op == OP_ADD || op == OP_SUB) begin
      res     = as_res;
      res_sat = as_sat;
    end else begin
      res     = m_res;
      res_sat = m_over;
    end
  end

  logic finish;
  always_comb begin
    case (op)
      OP_MUL:  finish = run && (cnt == CW'(4));
      OP_DIV:  finish = run && (cnt == CW'(DVD_W));
      default: finish = run;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      sat  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        sat <= 1'b0;
      end else if (cmd.issue) begin
        run <= 1'b1;
      end else if (finish) begin
        run  <= 1'b0;
        done <= 1'b1;
        sat  <= sat | res_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rf.r    <= VW'(request.growth_rate);
      rf.m    <= VW'(request.mixing_rate);
      rf.u    <= VW'(request.harvest_fraction);
      rf.p    <= VW'(request.protected_share);
      rf.kall <= VW'(request.capacity) << FRAC_BITS;
      rf.y    <= '0;
    end else if (cmd.issue) begin
      op  <= cmd.uop.op;
      dst <= cmd.uop.dst;
      opa <= va;
      opb <= vb;
      ma  <= mag(va);
      mb  <= mag(vb);
      neg <= va[VW-1] ^ vb[VW-1];
      cnt <= '0;
      acc <= '0;
      rem <= '0;
      quo <= '0;
      dvd <= {mag(va), {FRAC_BITS{1'b0}}};
    end else if (finish) begin
      case (dst)
        RG_B:    rf.b    <= res;
        RG_O:    rf.o    <= res;
        RG_Q:    rf.q    <= res;
        RG_MU:   rf.mu   <= res;
        RG_R:    rf.r    <= res;
        RG_U:    rf.u    <= res;
        RG_P:    rf.p    <= res;
        RG_M:    rf.m    <= res;
        RG_ONEP: rf.onep <= res;
        RG_ONEU: rf.oneu <= res;
        RG_KIN:  rf.kin  <= res;
        RG_KOUT: rf.kout <= res;
        RG_KALL: rf.kall <= res;
        RG_T1:   rf.t1   <= res;
        RG_T2:   rf.t2   <= res;
        RG_T3:   rf.t3   <= res;
        RG_FLOW: rf.flow <= res;
        RG_NB:   rf.nb   <= res;
        RG_Y:    rf.y    <= res;
        default: ;
      endcase
    end else if (run) begin
      cnt <= cnt + CW'(1);
      if (op == OP_MUL) begin
        acc <= acc + pp_sh;
      end else begin
        rem <= ge ? (remsh - {1'b0, mb}) : remsh;
        quo <= {quo[DVD_W-2:0], ge};
        dvd <= dvd << 1;
      end
    end
  end

  always_comb begin
    sts.done      = done;
    sts.sat       = sat;
    sts.onep_zero = rf.onep == '0;
    sts.kin_zero  = rf.kin == '0;
    sts.kout_zero = rf.kout == '0;
    sts.kall_zero = rf.kall == '0;
    sts.yield     = $signed(rf.y);
  end

endmodule

FILE: sv/hsim_ctrl.sv
// Controller of the harvest simulator: sequences micro-op programs over the
// datapath and counts years. Uses hsim_pkg.
module hsim_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                density_mode,
  input  logic [9:0]          year_count,
  input  hsim_pkg::dp_sts_t   sts,
  output hsim_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                done,
  output hsim_pkg::out_item_t result
);
  import hsim_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {PH_INIT, PH_QDIV, PH_YEAR} phase_t;

  state_t         state;
  phase_t         phase;
  logic [PCW-1:0] pc;
  logic [9:0]     years_left;
  logic           err;
  uop_t           uop;
  logic           div_zero;
  logic [PCW-1:0] year_pc;

  assign uop      = uop_rom(pc);
  assign year_pc  = density_mode ? PC_YEAR1 : PC_YEAR0;
  assign div_zero = sts.onep_zero |
                    (density_mode ? (sts.kin_zero | sts.kout_zero) : sts.kall_zero);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_INIT;
      pc         <= PC_INIT;
      years_left <= '0;
      err        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            err   <= 1'b0;
            pc    <= PC_INIT;
            phase <= PH_INIT;
            state <= (year_count == '0) ? S_DONE : S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (sts.done) begin
            if (!uop.last) begin
              pc    <= pc + PCW'(1);
              state <= S_ISSUE;
            end else begin
              case (phase)
                PH_INIT: state <= S_CHECK;
                PH_QDIV: begin
                  phase      <= PH_YEAR;
                  pc         <= year_pc;
                  years_left <= year_count;
                  state      <= S_ISSUE;
                end
                default: begin
                  if (years_left == 10'd1) begin
                    state <= S_DONE;
                  end else begin
                    years_left <= years_left - 10'd1;
                    pc         <= year_pc;
                    state      <= S_ISSUE;
                  end
                end
              endcase
            end
          end
        end
        S_CHECK: begin
          // any zero divisor aborts before the first year
          if (div_zero) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            phase <= PH_QDIV;
            pc    <= PC_QDIV;
            state <= S_ISSUE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.load  = (state == S_IDLE) && start;
    cmd.issue = state == S_ISSUE;
    cmd.uop   = uop;
    busy      = state != S_IDLE;
    done      = state == S_DONE;
    result.final_yield = err ? '0 : sts.yield;
    result.status      = err ? ST_DIVZ : (sts.sat ? ST_SAT : ST_OK);
  end

endmodule

FILE: sv/two_patch_logistic_harvest_sim.sv
// Top level of the two-patch logistic harvest simulator: APB registers,
// controller and datapath. Uses hsim_pkg, hsim_ctrl, hsim_dp.
//
//  channel   handshake                      payload
//  request   start & !busy                  request (in_item_t)
//  result    done, one cycle, no stall      result (out_item_t)
//  config    psel & penable & pwrite        paddr[2:0], pwdata / prdata
//
// Each micro-op passes through an issue state, its ALU run and a done strobe;
// a divide produces one quotient bit per cycle. Setup, the divisor check and
// the p/(1-p) divide run first, then the year program once per year, per patch
// or pooled by density_mode, then the result. A zero divisor ends the run after
// setup, before the divide; year_count 0 gives the result in the cycle after
// the request.
// Synchronous reset sets density_mode 0 and year_count 100.
// The result strobe is never held off by the receiver.
module two_patch_logistic_harvest_sim (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  hsim_pkg::in_item_t  request,
  output logic                done,
  output hsim_pkg::out_item_t result
);
  import hsim_pkg::*;

  logic       density_mode;
  logic [9:0] year_count;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      density_mode <= 1'b0;
      year_count   <= 10'd100;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        year_count <= pwdata[9:0];
      end else begin
        density_mode <= pwdata[0];
      end
    end
  end

  assign prdata = paddr[2] ? {22'd0, year_count} : {31'd0, density_mode};

  hsim_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .density_mode (density_mode),
    .year_count   (year_count),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done),
    .result       (result)
  );

  hsim_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

FILE: sv/hsim_checker.sv
// Port-level checker for the harvest simulator, bound to the top level.
// Uses hsim_pkg and two_patch_logistic_harvest_sim_defines.svh.
`include "two_patch_logistic_harvest_sim_defines.svh"

module hsim_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input hsim_pkg::out_item_t result
);
  import hsim_pkg::*;

  `HSIM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted request")
  `HSIM_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")
  `HSIM_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
  `HSIM_ASSERT_NOW(a_status_code, done, result.status != 2'd3, "undefined status code")
  `HSIM_ASSERT_NOW(a_divz_zero, done && result.status == ST_DIVZ, result.final_yield == '0, "nonzero yield on divide error")

endmodule

bind two_patch_logistic_harvest_sim hsim_checker u_chk (.*);
